// ----- hw/rtl/lbpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbpc_pkg: shared types and constants for the LED beacon power controller
// Request/response payloads, controller state, event and timer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpc_pkg;

   // Phase counter length (8..256)
   localparam int PHASES  = 32;
   localparam int PHASE_W = $clog2(PHASES);

   localparam logic [PHASE_W-1:0] PHASE_LAST      = PHASE_W'(PHASES - 1);
   localparam logic [PHASE_W-1:0] PHASE_FLASH_MID = PHASE_W'(PHASES - 2);
   localparam logic [PHASE_W-1:0] PHASE_SAMPLE    = PHASE_W'(PHASES - 3);

   localparam int LIGHT_W  = 10;
   localparam int MODE_W   = 8;
   localparam int ONTIME_W = 24;
   localparam int CSR_W    = 24;

   localparam logic [MODE_W-1:0]   MODE_OFF = 8'h00;
   localparam logic [MODE_W-1:0]   MODE_ON  = 8'hFF;

   localparam logic [LIGHT_W-1:0]  DARK_THRESHOLD_RST = 10'd600;
   localparam logic [ONTIME_W-1:0] ON_TIME_TICKS_RST  = 24'((3600000 * 12) / (32 * 120));

   // event kinds
   localparam logic CMD_BUTTON = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // timer interval codes
   localparam logic [1:0] WAIT_STOP  = 2'd0;
   localparam logic [1:0] WAIT_SHORT = 2'd1;
   localparam logic [1:0] WAIT_LONG  = 2'd2;

   // flash length codes
   localparam logic [1:0] FLASH_NONE  = 2'd0;
   localparam logic [1:0] FLASH_BRIEF = 2'd1;
   localparam logic [1:0] FLASH_MID   = 2'd2;
   localparam logic [1:0] FLASH_LONG  = 2'd3;

   // register indexes
   localparam logic REG_DARK_THRESHOLD = 1'b0;
   localparam logic REG_ON_TIME_TICKS  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic               button_held;
      logic [LIGHT_W-1:0] light_level;
   } lbpc_req_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        flash_length;
      logic [1:0]        next_wait;
      logic              button_wake;
      logic [MODE_W-1:0] mode_value;
   } lbpc_rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PHASE_W-1:0]  phase;
      logic [ONTIME_W-1:0] on_remaining;
      logic                is_dark;
      logic                button_wake_enabled;
      logic [1:0]          timer_wait;
   } lbpc_state_type;

   typedef struct packed {
      logic [LIGHT_W-1:0]  dark_threshold;
      logic [ONTIME_W-1:0] on_time_ticks;
   } lbpc_cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lbpc_step.sv -----
// ----------------------------------------------------------------------------
// lbpc_step: one-event state update
// Combinational next state and response for a single request.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpc_step (
   input  wire lbpc_pkg::lbpc_state_type state,
   input  wire lbpc_pkg::lbpc_cfg_type   cfg,
   input  wire lbpc_pkg::lbpc_req_type   req,
   output lbpc_pkg::lbpc_state_type      next_state,
   output lbpc_pkg::lbpc_rsp_type        rsp
);
   import lbpc_pkg::*;

   logic           take;
   lbpc_state_type nxt;
   logic [1:0]     flash;

   always_comb begin
      if (req.cmd == CMD_BUTTON) begin
         take = state.button_wake_enabled;
      end else begin
         take = (state.timer_wait != WAIT_STOP);
      end

      nxt = state;
      if (take) begin
         if (req.cmd == CMD_BUTTON) begin
            nxt.button_wake_enabled = 1'b0;
            nxt.timer_wait          = WAIT_SHORT;
            nxt.mode                = state.mode - 8'd1;
         end else begin
            nxt.timer_wait = WAIT_STOP;
            if (!req.button_held) begin
               nxt.button_wake_enabled = 1'b1;
               if (state.mode != MODE_OFF && state.on_remaining != '0) begin
                  nxt.mode       = MODE_ON;
                  nxt.timer_wait = WAIT_LONG;
                  if (state.phase == PHASE_LAST) begin
                     nxt.on_remaining = state.on_remaining - ONTIME_W'(1);
                  end
               end else begin
                  // on-time used up or mode ran to zero: switch off, reload
                  nxt.on_remaining = cfg.on_time_ticks;
                  nxt.mode         = MODE_OFF;
               end
            end else begin
               if (state.mode != MODE_OFF) begin
                  nxt.mode = state.mode - 8'd1;
               end
               nxt.timer_wait = WAIT_SHORT;
            end
            if (state.phase == PHASE_LAST) begin
               nxt.phase = '0;
            end else begin
               nxt.phase = state.phase + PHASE_W'(1);
            end
         end

         // light sample whenever an accepted event leaves the phase at the sample point, only with the button released
         if (nxt.phase == PHASE_SAMPLE && !req.button_held) begin
            nxt.is_dark = (req.light_level > cfg.dark_threshold);
         end
      end

      flash = FLASH_NONE;
      if (take && nxt.mode != MODE_OFF) begin
         flash = FLASH_BRIEF;
         if (nxt.mode == MODE_ON && nxt.is_dark) begin
            if (nxt.phase == PHASE_FLASH_MID) begin
               flash = FLASH_MID;
            end else if (nxt.phase == PHASE_LAST) begin
               flash = FLASH_LONG;
            end
         end
      end
   end

   assign next_state       = nxt;
   assign rsp.accepted     = take;
   assign rsp.flash_length = flash;
   assign rsp.next_wait    = nxt.timer_wait;
   assign rsp.button_wake  = nxt.button_wake_enabled;
   assign rsp.mode_value   = nxt.mode;

endmodule

`default_nettype wire

// ----- hw/rtl/led_beacon_power_controller.sv -----
// ----------------------------------------------------------------------------
// led_beacon_power_controller: flashing beacon mode/phase controller
// Handles button-wake and timer-tick events, reports flash and timer setup.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per event (button wake or timer tick) with the
//            button level and the averaged light reading. Disabled events
//            still return a response with accepted = 0 and state unchanged.
//   rsp_*  : one response per request: flash length, next timer interval,
//            button wake enable and the mode byte after the event.
//   csr_*  : register writes (0 dark_threshold, 1 on_time_ticks), taken in
//            the cycle csr_we is high; write only while the block is idle.
// Timing:
//   The whole update is one combinational pass from the controller state
//   and the request into the state registers and the response register.
//   The response is registered; a request can be taken every cycle while req_ready is high.
//   req_ready is high while the response register is empty or being read,
//   so a stalled receiver holds the response and back-pressures requests.
// Reset:
//   Synchronous, active high. Mode off, phase 0, on-time countdown 11250,
//   not dark, button wake enabled, timer stopped, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module led_beacon_power_controller (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire lbpc_pkg::lbpc_req_type  req_data,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output lbpc_pkg::lbpc_rsp_type       rsp_data,
   // register write port
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire [lbpc_pkg::CSR_W-1:0]    csr_wdata
);
   import lbpc_pkg::*;

   lbpc_state_type state_ff;
   lbpc_state_type state_in;
   lbpc_cfg_type   cfg_ff;
   lbpc_rsp_type   rsp_ff;
   lbpc_rsp_type   rsp_in;
   logic           rsp_valid_ff;
   logic           req_fire;

   // output register frees up when drained in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   lbpc_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .next_state (state_in),
      .rsp        (rsp_in)
   );

   // controller state: advances only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode                <= MODE_OFF;
         state_ff.phase               <= '0;
         state_ff.on_remaining        <= ON_TIME_TICKS_RST;
         state_ff.is_dark             <= 1'b0;
         state_ff.button_wake_enabled <= 1'b1;
         state_ff.timer_wait          <= WAIT_STOP;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold <= DARK_THRESHOLD_RST;
         cfg_ff.on_time_ticks  <= ON_TIME_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DARK_THRESHOLD: cfg_ff.dark_threshold <= csr_wdata[LIGHT_W-1:0];
            REG_ON_TIME_TICKS:  cfg_ff.on_time_ticks  <= csr_wdata[ONTIME_W-1:0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // every accepted request produces a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request did not load the response register");

   // a stopped timer must leave the button able to wake the beacon
   a_no_deadlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff.timer_wait == WAIT_STOP) |-> state_ff.button_wake_enabled)
      else $error("timer stopped with button wake disabled");

   // timer code stays within the defined intervals
   a_wait_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff.timer_wait == WAIT_STOP) || (state_ff.timer_wait == WAIT_SHORT) ||
      (state_ff.timer_wait == WAIT_LONG))
      else $error("undefined timer interval code");

   // no flash while the beacon is off, and none for an ignored event
   a_flash_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.flash_length != FLASH_NONE) |->
         (rsp_ff.mode_value != MODE_OFF) && rsp_ff.accepted)
      else $error("flash reported with beacon off or event ignored");

endmodule

`default_nettype wire

// ----- tb/lbpc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// lbpc_tb_pkg: beacon controller scoreboard
// Tracks the controller state for each accepted request and checks responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbpc_tb_pkg;

   import lbpc_pkg::*;

   class lbpc_scoreboard;

      // register copies
      logic [LIGHT_W-1:0]  dark_thr;
      logic [ONTIME_W-1:0] on_time;

      // controller state
      logic [MODE_W-1:0]   mode;
      logic [PHASE_W-1:0]  phase;
      logic [ONTIME_W-1:0] on_left;
      logic                dark;
      logic                wake_en;
      logic [1:0]          timer;

      lbpc_rsp_type        rsp_due[$];
      int unsigned         fails;

      function new();
         dark_thr = DARK_THRESHOLD_RST;
         on_time  = ON_TIME_TICKS_RST;
         mode     = MODE_OFF;
         phase    = '0;
         on_left  = ON_TIME_TICKS_RST;
         dark     = 1'b0;
         wake_en  = 1'b1;
         timer    = WAIT_STOP;
         fails    = 0;
      endfunction

      function void set_reg(logic idx, logic [CSR_W-1:0] val);
         if (idx == REG_DARK_THRESHOLD) begin
            dark_thr = val[LIGHT_W-1:0];
         end else begin
            on_time = val[ONTIME_W-1:0];
         end
      endfunction

      // Applies one accepted request to the state, queues and returns the
      // response it must produce.
      function lbpc_rsp_type note_request(lbpc_req_type r);
         lbpc_rsp_type o;
         logic         take;
         o    = '0;
         take = (r.cmd == CMD_BUTTON) ? wake_en : (timer != WAIT_STOP);
         if (take) begin
            if (r.cmd == CMD_BUTTON) begin
               wake_en = 1'b0;
               timer   = WAIT_SHORT;
               mode    = mode - 1'b1;
            end else begin
               timer = WAIT_STOP;
               if (!r.button_held) begin
                  wake_en = 1'b1;
                  if (mode != MODE_OFF && on_left != '0) begin
                     mode  = MODE_ON;
                     timer = WAIT_LONG;
                     if (phase == PHASE_LAST) begin
                        on_left = on_left - 1'b1;
                     end
                  end else begin
                     on_left = on_time;
                     mode    = MODE_OFF;
                  end
               end else begin
                  if (mode != MODE_OFF) begin
                     mode = mode - 1'b1;
                  end
                  timer = WAIT_SHORT;
               end
               phase = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
            end
            if (phase == PHASE_SAMPLE && !r.button_held) begin
               dark = (r.light_level > dark_thr);
            end
            if (mode == MODE_OFF) begin
               o.flash_length = FLASH_NONE;
            end else if (mode == MODE_ON && dark && phase == PHASE_FLASH_MID) begin
               o.flash_length = FLASH_MID;
            end else if (mode == MODE_ON && dark && phase == PHASE_LAST) begin
               o.flash_length = FLASH_LONG;
            end else begin
               o.flash_length = FLASH_BRIEF;
            end
         end
         o.accepted    = take;
         o.next_wait   = timer;
         o.button_wake = wake_en;
         o.mode_value  = mode;
         rsp_due.push_back(o);
         return o;
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
         end
      endfunction

      function void check_response(lbpc_rsp_type got);
         lbpc_rsp_type want;
         if (rsp_due.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            fails++;
            return;
         end
         want = rsp_due.pop_front();
         compare("accepted", want.accepted, got.accepted);
         compare("flash_length", want.flash_length, got.flash_length);
         compare("next_wait", want.next_wait, got.next_wait);
         compare("button_wake", want.button_wake, got.button_wake);
         compare("mode_value", want.mode_value, got.mode_value);
      endfunction

      function int outstanding();
         return rsp_due.size();
      endfunction

   endclass

endpackage

// ----- tb/tb_led_beacon_power_controller.sv -----
// ----------------------------------------------------------------------------
// tb_led_beacon_power_controller: LED beacon power controller testbench
// Drives button and tick requests with random idling on both channels,
// predicts every response in a scoreboard and checks it field by field,
// across several dark threshold / on-time register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_beacon_power_controller;

   import lbpc_pkg::*;
   import lbpc_tb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   lbpc_req_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   lbpc_rsp_type        rsp_data;
   logic                csr_we = 1'b0;
   logic                csr_index = REG_DARK_THRESHOLD;
   logic [CSR_W-1:0]    csr_wdata = '0;

   lbpc_scoreboard      sb;
   int unsigned         cycles = 0;
   // both sides stop idling while calm is set
   bit                  calm = 1'b0;
   // set by the sequence, picked up by the receiver to start a long stall
   bit                  hold_req = 1'b0;
   // remaining held ticks of the current button press
   int                  hold_left = 0;

   led_beacon_power_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost response ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_led_beacon_power_controller: FAIL");
         $finish;
      end
   end

   // Receiver: checks each response at its handshake edge, then picks the
   // next ready value. A hold request stalls it for a long, counted stretch
   // so the output register fills and req_ready drops.
   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
         end
         if (hold_req) begin
            hold_req = 1'b0;
            stall    = 180;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 36);
         end
      end
   end

   function automatic lbpc_req_type mk_req(logic c, logic h, int lvl);
      lbpc_req_type r;
      r.cmd         = c;
      r.button_held = h;
      r.light_level = LIGHT_W'(lvl);
      return r;
   endfunction

   // Offer one request, wait for its handshake and note it. Valid stays up
   // when the next request follows at once; otherwise it drops for the gap.
   task automatic issue(lbpc_req_type r, output bit took);
      lbpc_rsp_type want;
      int           gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = sb.note_request(r);
      took = want.accepted;
      gap  = 0;
      while (!calm && $urandom_range(99) < 36) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Next random request. Mostly follows the beacon's own life cycle
   // (press, held ticks, release, long ticks) so deep states get reached;
   // a share is plain noise, which is often ignored by the block.
   task automatic next_request(output lbpc_req_type r);
      int roll;
      int lvl;
      roll = $urandom_range(99);
      case ($urandom_range(9))
         0:       lvl = 0;
         1:       lvl = 1023;
         2, 3: begin
            lvl = int'(sb.dark_thr) + int'($urandom_range(4)) - 2;
            if (lvl < 0) lvl = 0;
            if (lvl > 1023) lvl = 1023;
         end
         default: lvl = $urandom_range(1023);
      endcase
      r = mk_req(1'b0, 1'b0, lvl);
      if (roll < 12) begin
         r.cmd         = 1'($urandom_range(1));
         r.button_held = 1'($urandom_range(1));
      end else if (sb.timer != WAIT_STOP && !(sb.wake_en && roll < 18)) begin
         r.cmd         = CMD_TICK;
         r.button_held = (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end else begin
         // new press: short taps mostly, now and then a hold long enough
         // to count the mode all the way down to off
         r.cmd         = CMD_BUTTON;
         r.button_held = 1'($urandom_range(1));
         roll          = $urandom_range(99);
         if (roll < 62)      hold_left = $urandom_range(4);
         else if (roll < 85) hold_left = $urandom_range(40, 5);
         else                hold_left = $urandom_range(300, 250);
      end
   endtask

   // random requests until n of them were taken by the block
   task automatic run_random(int n);
      lbpc_req_type r;
      bit           took;
      int           done;
      done = 0;
      while (done < n) begin
         next_request(r);
         issue(r, took);
         if (took) done++;
      end
   endtask

   // sender stops and waits until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   initial begin : sequence_main
      lbpc_req_type directed[$];
      bit           took;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: tick while the timer is stopped, press from off (wraps
      // to on), press while button wake is disabled, held and released
      // ticks, a held tick during a long wait, light extremes.
      directed.push_back(mk_req(CMD_TICK,   1'b0, 0));
      directed.push_back(mk_req(CMD_BUTTON, 1'b0, 1023));
      directed.push_back(mk_req(CMD_BUTTON, 1'b1, 0));
      directed.push_back(mk_req(CMD_TICK,   1'b1, 1023));
      directed.push_back(mk_req(CMD_TICK,   1'b1, 601));
      directed.push_back(mk_req(CMD_TICK,   1'b0, 600));
      directed.push_back(mk_req(CMD_TICK,   1'b0, 1023));
      directed.push_back(mk_req(CMD_BUTTON, 1'b1, 1023));
      directed.push_back(mk_req(CMD_TICK,   1'b0, 0));
      directed.push_back(mk_req(CMD_TICK,   1'b1, 0));
      directed.push_back(mk_req(CMD_TICK,   1'b1, 1023));
      directed.push_back(mk_req(CMD_TICK,   1'b0, 512));
      directed.push_back(mk_req(CMD_BUTTON, 1'b0, 1023));
      directed.push_back(mk_req(CMD_BUTTON, 1'b0, 1023));
      directed.push_back(mk_req(CMD_TICK,   1'b0, 1023));
      foreach (directed[i]) issue(directed[i], took);

      // reset register values
      run_random(300);
      drain();

      // lowest threshold, shortest on-time
      write_reg(REG_DARK_THRESHOLD, CSR_W'(0));
      write_reg(REG_ON_TIME_TICKS, CSR_W'(1));
      run_random(330);
      drain();

      // highest threshold, longest on-time; receiver stalls long while
      // the sender keeps pushing requests
      write_reg(REG_DARK_THRESHOLD, CSR_W'(1023));
      write_reg(REG_ON_TIME_TICKS, CSR_W'(24'hFFFFFF));
      hold_req = 1'b1;
      run_random(330);
      drain();

      // on-time of zero: once reloaded, every release switches off
      write_reg(REG_DARK_THRESHOLD, CSR_W'(512));
      write_reg(REG_ON_TIME_TICKS, CSR_W'(0));
      run_random(330);
      drain();

      // random threshold, short on-time; first stretch back to back
      write_reg(REG_DARK_THRESHOLD, CSR_W'($urandom_range(1023)));
      write_reg(REG_ON_TIME_TICKS, CSR_W'($urandom_range(6, 2)));
      calm = 1'b1;
      run_random(150);
      calm = 1'b0;
      run_random(180);
      drain();

      write_reg(REG_DARK_THRESHOLD, CSR_W'(600));
      write_reg(REG_ON_TIME_TICKS, CSR_W'(3));
      run_random(330);
      drain();

      repeat (5) @(posedge clock);
      if (sb.fails == 0 && sb.outstanding() == 0) begin
         $display("tb_led_beacon_power_controller: PASS");
      end else begin
         $display("tb_led_beacon_power_controller: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lbpc_pkg.sv
hw/rtl/lbpc_step.sv
hw/rtl/led_beacon_power_controller.sv
tb/lbpc_tb_pkg.sv
tb/tb_led_beacon_power_controller.sv
